// ===== src/rv64se_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64se_pkg
// Shared types and constants for the RV64 subset execute unit.
// ----------------------------------------------------------------------------
package rv64se_pkg;

    localparam int REG_COUNT = 32;
    localparam int CSR_COUNT = 4096;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int CSR_AW    = $clog2(CSR_COUNT);

    localparam logic [63:0] RESET_SP = 64'd256;

    // Opcodes.
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // Function codes.
    localparam logic [2:0] F3_DOUBLE = 3'd3;
    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_AND    = 3'd7;
    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [1:0] CSR_OP_RW = 2'd1;
    localparam logic [1:0] CSR_OP_RS = 2'd2;
    localparam logic [1:0] CSR_OP_RC = 2'd3;

    // CSR addresses with special handling.
    localparam logic [CSR_AW-1:0] CSR_SIE     = 12'h104;
    localparam logic [CSR_AW-1:0] CSR_MIE     = 12'h304;
    localparam logic [CSR_AW-1:0] CSR_MIDELEG = 12'h303;

    // Command codes.
    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Memory operation codes.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    // Status codes.
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_UNIMP = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instr_word;
        logic [63:0] load_data;
    } item_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [1:0]  mem_op;
        logic [63:0] mem_addr;
        logic [63:0] mem_wdata;
        logic        status;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [63:0]       data;
    } rf_wr_t;

    typedef struct packed {
        logic              en;
        logic [CSR_AW-1:0] addr;
        logic [63:0]       data;
    } csr_wr_t;

endpackage

// ===== src/rv64se_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64se_regfile
// Integer register file: synchronous memory with two read ports, one write
// port, per-entry valid bits for reset values and same-edge write forwarding.
// ----------------------------------------------------------------------------
module rv64se_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [rv64se_pkg::REG_AW-1:0] rs1_addr,
    input  logic [rv64se_pkg::REG_AW-1:0] rs2_addr,
    input  rv64se_pkg::rf_wr_t            wr,
    output logic [63:0]                   rs1_data,
    output logic [63:0]                   rs2_data
);

    logic [63:0]                   mem [rv64se_pkg::REG_COUNT];
    logic [rv64se_pkg::REG_COUNT-1:0] vld_reg;
    logic [63:0]                   q1_reg;
    logic [63:0]                   q2_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          b1_reg;
    logic                          b2_reg;
    logic [63:0]                   bd_reg;
    logic [rv64se_pkg::REG_AW-1:0] a1_reg;
    logic [rv64se_pkg::REG_AW-1:0] a2_reg;

    function automatic logic [63:0] reset_value(input logic [rv64se_pkg::REG_AW-1:0] idx);
        logic [63:0] v;
        begin
            v = (idx == rv64se_pkg::REG_AW'(2)) ? rv64se_pkg::RESET_SP : 64'd0;
            return v;
        end
    endfunction

    // Memory write and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q1_reg <= mem[rs1_addr];
            q2_reg <= mem[rs2_addr];
            bd_reg <= wr.data;
            a1_reg <= rs1_addr;
            a2_reg <= rs2_addr;
        end
    end

    // Valid bits and forwarding flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            b1_reg  <= 1'b0;
            b2_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                v1_reg <= vld_reg[rs1_addr];
                v2_reg <= vld_reg[rs2_addr];
                b1_reg <= wr.en && (wr.addr == rs1_addr);
                b2_reg <= wr.en && (wr.addr == rs2_addr);
            end
        end
    end

    // Resolve the operand values.
    assign rs1_data = b1_reg ? bd_reg : (v1_reg ? q1_reg : reset_value(a1_reg));
    assign rs2_data = b2_reg ? bd_reg : (v2_reg ? q2_reg : reset_value(a2_reg));

endmodule

// ===== src/rv64se_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64se_csr
// CSR store: 4096-entry synchronous memory with one read and one write port,
// same-edge write forwarding and a clearing pass after reset.
// ----------------------------------------------------------------------------
module rv64se_csr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [rv64se_pkg::CSR_AW-1:0] rd_addr,
    input  rv64se_pkg::csr_wr_t           wr,
    output logic [63:0]                   rd_data,
    output logic                          busy
);

    logic [63:0]                 mem [rv64se_pkg::CSR_COUNT];
    logic [rv64se_pkg::CSR_AW:0] clr_cnt_reg;
    logic [63:0]                 q_reg;
    logic [63:0]                 bd_reg;
    logic                        byp_reg;

    assign busy = !clr_cnt_reg[rv64se_pkg::CSR_AW];

    // Clearing pass counter, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            if (busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (rd_en)
            begin
                byp_reg <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    // Memory port; the clearing pass owns the write port while busy.
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[clr_cnt_reg[rv64se_pkg::CSR_AW-1:0]] <= 64'd0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_reg  <= mem[rd_addr];
            bd_reg <= wr.data;
        end
    end

    assign rd_data = byp_reg ? bd_reg : q_reg;

endmodule

// ===== src/rv64_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64_subset_execute_unit
// Executes LD, SD, ADD, AND, ADDI, BEQ, BNE and Zicsr instructions, one per
// transaction, against a register file and a CSR store kept in memories.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction reads its operands from the memories, then
// is executed and written back into the output register.
// Throughput: one transaction per cycle unless result_stall holds the output; writes are forwarded to the next read.
// Reset: after rst_n is released, a clearing pass zeroes all 4096 entries of the
// CSR store, during which item_stall stays high.
module rv64_subset_execute_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rv64se_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output rv64se_pkg::result_t result
);

    logic                 csr_busy;
    logic                 in_fire;
    logic                 exec_move;
    logic                 exec_valid_reg;
    rv64se_pkg::item_t    exec_item_reg;
    logic                 out_valid_reg;
    rv64se_pkg::result_t  out_reg;
    logic [63:0]          pc_reg;
    logic [63:0]          pc_next;
    logic [63:0]          mie_reg;
    logic [63:0]          mie_next;
    logic [63:0]          mideleg_reg;
    logic [63:0]          mideleg_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [rv64se_pkg::REG_AW-1:0] pend_dest_reg;
    logic [rv64se_pkg::REG_AW-1:0] pend_dest_next;
    rv64se_pkg::rf_wr_t   rf_wr;
    rv64se_pkg::csr_wr_t  csr_wr;
    rv64se_pkg::result_t  res;
    logic [63:0]          rs1_val;
    logic [63:0]          rs2_val;
    logic [63:0]          csr_mem_val;

    // Decode fields.
    logic [31:0] w;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [6:0]  f7;
    logic [11:0] csr_addr;
    logic [63:0] immi;
    logic [63:0] imms;
    logic [63:0] immb;
    logic [63:0] csr_old;
    logic [63:0] csr_src;
    logic [63:0] csr_new;
    logic        csr_wen;

    assign w        = exec_item_reg.instr_word;
    assign opc      = w[6:0];
    assign rd       = w[11:7];
    assign f3       = w[14:12];
    assign rs1      = w[19:15];
    assign f7       = w[31:25];
    assign csr_addr = w[31:20];
    assign immi     = {{52{w[31]}}, w[31:20]};
    assign imms     = {{52{w[31]}}, w[31:25], w[11:7]};
    assign immb     = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};

    // Handshake.
    assign exec_move    = exec_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = csr_busy || (exec_valid_reg && !exec_move);
    assign in_fire      = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    rv64se_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_fire),
        .rs1_addr (item.instr_word[19:15]),
        .rs2_addr (item.instr_word[24:20]),
        .wr       (rf_wr),
        .rs1_data (rs1_val),
        .rs2_data (rs2_val)
    );

    rv64se_csr u_csr (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (item.instr_word[31:20]),
        .wr      (csr_wr),
        .rd_data (csr_mem_val),
        .busy    (csr_busy)
    );

    // CSR read view; SIE is MIE masked by MIDELEG.
    always_comb
    begin
        if (csr_addr == rv64se_pkg::CSR_SIE)
        begin
            csr_old = mie_reg & mideleg_reg;
        end
        else if (csr_addr == rv64se_pkg::CSR_MIE)
        begin
            csr_old = mie_reg;
        end
        else if (csr_addr == rv64se_pkg::CSR_MIDELEG)
        begin
            csr_old = mideleg_reg;
        end
        else
        begin
            csr_old = csr_mem_val;
        end
    end

    assign csr_src = f3[2] ? {59'd0, rs1} : rs1_val;

    // Execute: result, register write back and CSR update.
    always_comb
    begin
        res             = '0;
        res.mem_op      = rv64se_pkg::MEM_NONE;
        res.status      = rv64se_pkg::ST_OK;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        pend_dest_next  = pend_dest_reg;
        rf_wr           = '0;
        csr_wen         = 1'b0;
        csr_new         = '0;
        if (exec_item_reg.cmd == rv64se_pkg::CMD_LOAD)
        begin
            if (pend_valid_reg)
            begin
                rf_wr.en        = 1'b1;
                rf_wr.addr      = pend_dest_reg;
                rf_wr.data      = exec_item_reg.load_data;
                pend_valid_next = 1'b0;
            end
        end
        else
        begin
            pc_next = pc_reg + 64'd4;
            unique case (opc)
                rv64se_pkg::OPC_LOAD:
                begin
                    if (f3 == rv64se_pkg::F3_DOUBLE)
                    begin
                        res.mem_op      = rv64se_pkg::MEM_READ;
                        res.mem_addr    = rs1_val + immi;
                        pend_valid_next = 1'b1;
                        pend_dest_next  = rd;
                    end
                    else
                    begin
                        res.status = rv64se_pkg::ST_UNIMP;
                    end
                end
                rv64se_pkg::OPC_STORE:
                begin
                    if (f3 == rv64se_pkg::F3_DOUBLE)
                    begin
                        res.mem_op    = rv64se_pkg::MEM_WRITE;
                        res.mem_addr  = rs1_val + imms;
                        res.mem_wdata = rs2_val;
                    end
                    else
                    begin
                        res.status = rv64se_pkg::ST_UNIMP;
                    end
                end
                rv64se_pkg::OPC_OP:
                begin
                    rf_wr.addr = rd;
                    if (f7 == 7'd0 && f3 == rv64se_pkg::F3_ADD)
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wr.data = rs1_val + rs2_val;
                    end
                    else if (f7 == 7'd0 && f3 == rv64se_pkg::F3_AND)
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wr.data = rs1_val & rs2_val;
                    end
                    else
                    begin
                        res.status = rv64se_pkg::ST_UNIMP;
                    end
                end
                rv64se_pkg::OPC_OP_IMM:
                begin
                    if (f3 == rv64se_pkg::F3_ADD)
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wr.addr = rd;
                        rf_wr.data = rs1_val + immi;
                    end
                    else
                    begin
                        res.status = rv64se_pkg::ST_UNIMP;
                    end
                end
                rv64se_pkg::OPC_BRANCH:
                begin
                    if (f3 == rv64se_pkg::F3_BEQ)
                    begin
                        if (rs1_val == rs2_val)
                        begin
                            pc_next = pc_reg + immb;
                        end
                    end
                    else if (f3 == rv64se_pkg::F3_BNE)
                    begin
                        if (rs1_val != rs2_val)
                        begin
                            pc_next = pc_reg + immb;
                        end
                    end
                    else
                    begin
                        res.status = rv64se_pkg::ST_UNIMP;
                    end
                end
                rv64se_pkg::OPC_SYSTEM:
                begin
                    rf_wr.addr = rd;
                    rf_wr.data = csr_old;
                    unique case (f3[1:0])
                        rv64se_pkg::CSR_OP_RW:
                        begin
                            rf_wr.en = 1'b1;
                            csr_wen  = 1'b1;
                            csr_new  = csr_src;
                        end
                        rv64se_pkg::CSR_OP_RS:
                        begin
                            rf_wr.en = 1'b1;
                            csr_wen  = (rs1 != 5'd0);
                            csr_new  = csr_old | csr_src;
                        end
                        rv64se_pkg::CSR_OP_RC:
                        begin
                            rf_wr.en = 1'b1;
                            csr_wen  = (rs1 != 5'd0);
                            csr_new  = csr_old & ~csr_src;
                        end
                        default:
                        begin
                            res.status = rv64se_pkg::ST_UNIMP;
                        end
                    endcase
                end
                default:
                begin
                    res.status = rv64se_pkg::ST_UNIMP;
                end
            endcase
        end
        // x0 is never written; nothing is written unless the transaction moves on.
        rf_wr.en    = rf_wr.en && (rf_wr.addr != '0) && exec_move;
        csr_wen     = csr_wen && exec_move;
        res.next_pc = pc_next;
    end

    // Route CSR writes to the MIE/MIDELEG registers or the store.
    always_comb
    begin
        mie_next     = mie_reg;
        mideleg_next = mideleg_reg;
        csr_wr       = '0;
        csr_wr.addr  = csr_addr;
        csr_wr.data  = csr_new;
        if (csr_wen)
        begin
            if (csr_addr == rv64se_pkg::CSR_SIE)
            begin
                mie_next = (mie_reg & ~mideleg_reg) | (csr_new & mideleg_reg);
            end
            else if (csr_addr == rv64se_pkg::CSR_MIE)
            begin
                mie_next = csr_new;
            end
            else if (csr_addr == rv64se_pkg::CSR_MIDELEG)
            begin
                mideleg_next = csr_new;
            end
            else
            begin
                csr_wr.en = 1'b1;
            end
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= '0;
            mie_reg        <= '0;
            mideleg_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_dest_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                exec_valid_reg <= 1'b1;
            end
            else if (exec_move)
            begin
                exec_valid_reg <= 1'b0;
            end
            if (exec_move)
            begin
                out_valid_reg  <= 1'b1;
                pc_reg         <= pc_next;
                mie_reg        <= mie_next;
                mideleg_reg    <= mideleg_next;
                pend_valid_reg <= pend_valid_next;
                pend_dest_reg  <= pend_dest_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            exec_item_reg <= item;
        end
        if (exec_move)
        begin
            out_reg <= res;
        end
    end

    // Assertions.
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        csr_busy |-> !in_fire)
        else $error("transaction accepted during CSR clearing pass");

    a_accept_fills_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> exec_valid_reg)
        else $error("accepted transaction lost before execute");

    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall && exec_valid_reg) |-> item_stall)
        else $error("input taken while pipeline is full");

    a_mem_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.mem_op != 2'd3))
        else $error("illegal memory operation code");

endmodule
